FILE: design/hedpf_pkg.sv
`timescale 1ns / 1ps

package hedpf_pkg;

  // Default geometry
  localparam int MAX_HULL_DEF   = 256;
  localparam int COORD_BITS_DEF = 12;

  // Distance threshold register, unsigned Q12.4
  localparam int DIST_W = 16;
  localparam int D2_W   = 2 * DIST_W;
  localparam logic [DIST_W-1:0] DIST_RESET = 16'd16;

  // Squared Q4 fraction: cross^2 is scaled by 2^(2*4)
  localparam int SQ_FRAC_BITS = 8;

  // Input word function codes
  localparam logic FUNC_HULL = 1'b0;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_DIST   = 0;

endpackage

FILE: design/hull_edge_distance_point_filter.sv
`timescale 1ns / 1ps
// Hull-edge distance point filter.
// Input channel (in_valid/in_ready) carries one word per point. A word with
// func = hull loads a convex hull point into the on-chip table; the first hull
// word after a contour starts a fresh table. A word with func = point presents
// a contour point and produces exactly one result word on the output channel
// (out_valid/out_ready): the point, its keep flag, end_of_contour and
// start_missing. Hull words produce no result.
// Throughput: a hull word is taken every cycle while no point is in flight. A
// contour point passes through the table read and then the five-stage
// multiply/compare pipeline to its result (a point with an empty table skips
// both); the input is ready again once the result is in the output register.
// The first point of a contour also walks the hull table once, one entry per
// cycle. One point is in flight at a time.
// The result sits in an output register, so the next word is accepted while
// a stalled result waits; a finished result then holds until the output
// register frees up.
// Reset (rst, synchronous) empties the hull count, clears the contour state
// and sets the threshold register to 1.0 pixel; the table is not cleared.
// The user writes the threshold over the APB port while idle (not enforced).
module hull_edge_distance_point_filter #(
  parameter int MAX_HULL   = hedpf_pkg::MAX_HULL_DEF,
  parameter int COORD_BITS = hedpf_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [COORD_BITS-1:0]             px,
  input  logic [COORD_BITS-1:0]             py,
  input  logic                              last,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COORD_BITS-1:0]             out_x,
  output logic [COORD_BITS-1:0]             out_y,
  output logic                              keep,
  output logic                              end_of_contour,
  output logic                              start_missing,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hedpf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [hedpf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hedpf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import hedpf_pkg::*;

  localparam int IDX_W = $clog2(MAX_HULL);
  localparam int CNT_W = $clog2(MAX_HULL + 1);
  localparam int ENT_W = 2 * COORD_BITS;
  localparam int RIDX_W = APB_ADDR_W - 2;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_READ   = 7'b0000100,
    S_DIFF   = 7'b0001000,
    S_CALC   = 7'b0010000,
    S_DONE   = 7'b0100000,
    S_HOLD   = 7'b1000000
  } state_t;

  state_t state;

  logic [DIST_W-1:0]     dist_q4;
  logic [CNT_W-1:0]      hull_count;
  logic [IDX_W-1:0]      start_idx, end_idx;
  logic                  started, closed, missing;
  logic [COORD_BITS-1:0] pt_x, pt_y;
  logic                  pt_last;
  logic [CNT_W-1:0]      srch_idx;
  logic                  srch_pend;
  logic [IDX_W-1:0]      srch_pend_idx;
  logic                  res_keep;

  logic [ENT_W-1:0]      hull_mem [MAX_HULL];
  logic [ENT_W-1:0]      rd_a, rd_b;
  logic [IDX_W-1:0]      addr_a;

  logic                  in_take, hull_take, point_take;
  logic [CNT_W-1:0]      wr_base;
  logic                  wr_ok;
  logic                  srch_hit, end_hit;
  logic                  out_load;
  logic                  cfg_write;
  logic [RIDX_W-1:0]     reg_idx;
  logic                  dist_go, dist_done, dist_keep;

  // Entry before idx, wrapping at the hull count
  function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] cnt_m1;
    cnt_m1 = cnt - 1'b1;
    if (idx == '0) return cnt_m1[IDX_W-1:0];
    return idx - 1'b1;
  endfunction

  // Handshake and table write decode
  assign in_ready   = (state == S_IDLE);
  assign in_take    = in_valid && in_ready;
  assign hull_take  = in_take && (func == FUNC_HULL);
  assign point_take = in_take && (func != FUNC_HULL);
  assign wr_base    = closed ? '0 : hull_count;
  assign wr_ok      = (wr_base < CNT_W'(MAX_HULL));

  // Search port walks the table, otherwise it fetches the edge start
  assign addr_a = (state == S_SEARCH && srch_idx < hull_count) ?
                  srch_idx[IDX_W-1:0] : start_idx;

  // Hull table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (hull_take && wr_ok) hull_mem[wr_base[IDX_W-1:0]] <= {px, py};
    rd_a <= hull_mem[addr_a];
    rd_b <= hull_mem[end_idx];
  end

  assign srch_hit = srch_pend && (rd_a == {pt_x, pt_y});
  assign end_hit  = (rd_b == {pt_x, pt_y});
  assign dist_go  = (state == S_DIFF);

  // Load the output register once a finished result finds it free
  assign out_load = (state == S_DONE || state == S_HOLD) && (!out_valid || out_ready);

  // Configuration port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready && (reg_idx == RIDX_W'(REG_DIST));
  assign prdata    = (reg_idx == RIDX_W'(REG_DIST)) ?
                     {{(APB_DATA_W-DIST_W){1'b0}}, dist_q4} : '0;

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dist_q4    <= DIST_RESET;
      hull_count <= '0;
      start_idx  <= '0;
      end_idx    <= '0;
      started    <= 1'b0;
      closed     <= 1'b1;
      missing    <= 1'b0;
      srch_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) dist_q4 <= pwdata[DIST_W-1:0];
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            pt_x    <= px;
            pt_y    <= py;
            pt_last <= last;
          end
          // Load a hull point, starting a fresh table after a contour
          if (hull_take) begin
            if (closed) started <= 1'b0;
            if (wr_ok) hull_count <= wr_base + 1'b1;
            closed <= last;
          end
          // Contour point: with an empty table drop it, else search on first point, then test against the edge
          if (point_take) begin
            closed  <= 1'b1;
            started <= !last;
            if (hull_count == '0) begin
              res_keep <= 1'b0;
              if (!started) begin
                missing   <= 1'b1;
                start_idx <= '0;
                end_idx   <= '0;
              end
              state <= S_DONE;
            end else if (!started) begin
              srch_idx  <= '0;
              srch_pend <= 1'b0;
              state     <= S_SEARCH;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_SEARCH: begin
          if (srch_hit) begin
            start_idx <= srch_pend_idx;
            end_idx   <= prev_idx(srch_pend_idx, hull_count);
            missing   <= 1'b0;
            state     <= S_READ;
          end else if (srch_idx == hull_count) begin
            start_idx <= '0;
            end_idx   <= prev_idx('0, hull_count);
            missing   <= 1'b1;
            state     <= S_READ;
          end else begin
            srch_pend     <= 1'b1;
            srch_pend_idx <= srch_idx[IDX_W-1:0];
            srch_idx      <= srch_idx + 1'b1;
          end
        end
        S_READ: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          // Step the edge back when the point reaches its far end
          if (end_hit) begin
            start_idx <= end_idx;
            end_idx   <= prev_idx(end_idx, hull_count);
          end
          state <= S_CALC;
        end
        S_CALC: begin
          if (dist_done) begin
            res_keep <= dist_keep;
            state    <= S_DONE;
          end
        end
        S_DONE, S_HOLD: begin
          // Hold until the output register is free
          if (out_load) begin
            out_x          <= pt_x;
            out_y          <= pt_y;
            keep           <= res_keep;
            end_of_contour <= pt_last;
            start_missing  <= missing;
            state          <= S_IDLE;
          end else begin
            state <= S_HOLD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Distance test pipeline
  hedpf_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .go      (dist_go),
    .dist_q4 (dist_q4),
    .start_x (rd_a[ENT_W-1:COORD_BITS]),
    .start_y (rd_a[COORD_BITS-1:0]),
    .end_x   (rd_b[ENT_W-1:COORD_BITS]),
    .end_y   (rd_b[COORD_BITS-1:0]),
    .pt_x    (pt_x),
    .pt_y    (pt_y),
    .done    (dist_done),
    .keep    (dist_keep)
  );

endmodule

FILE: design/hedpf_dist.sv
`timescale 1ns / 1ps

module hedpf_dist #(
  parameter int COORD_BITS = hedpf_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [hedpf_pkg::DIST_W-1:0]  dist_q4,
  input  logic [COORD_BITS-1:0]         start_x,
  input  logic [COORD_BITS-1:0]         start_y,
  input  logic [COORD_BITS-1:0]         end_x,
  input  logic [COORD_BITS-1:0]         end_y,
  input  logic [COORD_BITS-1:0]         pt_x,
  input  logic [COORD_BITS-1:0]         pt_y,
  output logic                          done,
  output logic                          keep
);
  import hedpf_pkg::*;

  localparam int D_W = COORD_BITS + 1;       // signed coordinate difference
  localparam int P_W = 2 * D_W;              // signed product
  localparam int A_W = 2 * COORD_BITS + 1;   // |cross| and squared length
  localparam int L_W = 2 * A_W;              // cross squared
  localparam int R_W = D2_W + A_W;           // threshold squared times length squared
  localparam int S_W = L_W + SQ_FRAC_BITS;
  localparam int C_W = (S_W > R_W) ? S_W : R_W;

  logic [3:0] stage_vld;

  logic signed [D_W-1:0] ex, ey, cx, cy;
  logic signed [P_W-1:0] p_ex_cy, p_ey_cx, p_ex_ex, p_ey_ey;
  logic [D2_W-1:0]       d2;
  logic [A_W-1:0]        acr, len2;
  logic [L_W-1:0]        lhs;
  logic [R_W-1:0]        rhs;
  logic                  len_zero;

  logic signed [P_W-1:0] cross_raw, cross_abs;
  logic [S_W-1:0]        lhs_scaled;

  // Track which stage holds the live word
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
      done      <= 1'b0;
    end else begin
      stage_vld <= {stage_vld[2:0], go};
      done      <= stage_vld[3];
    end
  end

  // Stage 1: edge and point vectors relative to the edge start
  always_ff @(posedge clk) begin
    if (go) begin
      ex <= $signed({1'b0, end_x}) - $signed({1'b0, start_x});
      ey <= $signed({1'b0, end_y}) - $signed({1'b0, start_y});
      cx <= $signed({1'b0, pt_x}) - $signed({1'b0, start_x});
      cy <= $signed({1'b0, pt_y}) - $signed({1'b0, start_y});
    end
  end

  // Stage 2: partial products and threshold squared
  always_ff @(posedge clk) begin
    p_ex_cy <= ex * cy;
    p_ey_cx <= ey * cx;
    p_ex_ex <= ex * ex;
    p_ey_ey <= ey * ey;
    d2      <= dist_q4 * dist_q4;
  end

  // Stage 3: absolute cross product and squared edge length
  always_comb begin
    cross_raw = p_ex_cy - p_ey_cx;
    cross_abs = cross_raw[P_W-1] ? -cross_raw : cross_raw;
  end

  always_ff @(posedge clk) begin
    acr  <= cross_abs[A_W-1:0];
    len2 <= p_ex_ex[A_W-1:0] + p_ey_ey[A_W-1:0];
  end

  // Stage 4: both sides of the distance test
  always_ff @(posedge clk) begin
    lhs      <= acr * acr;
    rhs      <= d2 * len2;
    len_zero <= (len2 == '0);
  end

  // Stage 5: compare; a zero-length edge keeps nothing
  assign lhs_scaled = {lhs, {SQ_FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    keep <= !len_zero && (C_W'(lhs_scaled) < C_W'(rhs));
  end

endmodule
